// ===== design/trnr_pkg.sv =====
// ----------------------------------------------------------------------------
// trnr_pkg - shared types and constants for the texel remap block
// Texel layout, mode codes, register indexes and fixed-point widths used by
// the input stage, the length pipeline and the divider lanes.
// ----------------------------------------------------------------------------
package trnr_pkg;

  localparam int PIX_W      = 8;
  localparam int CHAN_N     = 4;
  localparam int SEL_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // signed component s = 2*b - 255
  localparam int S_W        = 9;
  localparam int SQ_W       = 16;
  localparam int SUM_W      = 18;
  localparam int FRAC_BITS  = 16;
  localparam int ROOT_W     = (SUM_W + 2 * FRAC_BITS) / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SUM_STEPS  = ROOT_W - FRAC_BITS;

  // divider lane
  localparam int TOP_W      = ROOT_W + 2;
  localparam int N_W        = ROOT_W + 1 + PIX_W;
  localparam int QUO_W      = 9;
  localparam int DIV_LAT    = QUO_W + 3;

  localparam logic [S_W:0]       S_OFFSET      = (S_W + 1)'(255);
  localparam logic [PIX_W-1:0]   PIX_MAX       = 8'hFF;
  localparam logic [PIX_W-1:0]   PIX_ZERO      = 8'h00;
  localparam logic [PIX_W-1:0]   ZERO_VEC_BYTE = 8'h80;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SELECT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SELECT = 2'd2;

  typedef enum logic [1:0] {
    MODE_PASS   = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_TWO_CH = 2'd2,
    MODE_ONE_CH = 2'd3
  } mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } texel_t;

  typedef struct packed {
    logic                  normal;
    logic signed [S_W-1:0] sx;
    logic signed [S_W-1:0] sy;
    texel_t                texel;
  } tag_t;

endpackage

// ===== design/trnr_if.sv =====
// ----------------------------------------------------------------------------
// trnr_if - channel interfaces of the texel remap block
// Input texel, result texel and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface trnr_in_if import trnr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic [PIX_W-1:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface trnr_out_if import trnr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic [PIX_W-1:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

interface trnr_cfg_if import trnr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/trnr_sqrt.sv =====
// ----------------------------------------------------------------------------
// trnr_sqrt - vector length pipeline
// Squares and sums the three components, then takes floor(sqrt(sum << 32))
// one result bit per stage. The texel tag travels alongside.
// ----------------------------------------------------------------------------
module trnr_sqrt import trnr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  tag_t                  in_tag,
  input  logic signed [S_W-1:0] in_sz,
  output logic                  out_valid,
  output tag_t                  out_tag,
  output logic [ROOT_W-1:0]     out_root
);

  logic signed [2*S_W-1:0] px, py, pz;
  logic [SQ_W-1:0]         sqx_r, sqy_r, sqz_r;
  logic                    sq_vld_r;
  tag_t                    sq_tag_r;
  logic [SUM_W-1:0]        sum_nxt;

  logic                    vld_r  [0:ROOT_W];
  tag_t                    tag_r  [0:ROOT_W];
  logic [ROOT_W-1:0]       root_r [0:ROOT_W];
  logic [REM_W-1:0]        rem_r  [0:ROOT_W-1];
  logic [SUM_W-1:0]        sum_r  [0:SUM_STEPS-1];

  always_comb begin
    px = $signed(in_tag.sx) * $signed(in_tag.sx);
    py = $signed(in_tag.sy) * $signed(in_tag.sy);
    pz = $signed(in_sz) * $signed(in_sz);
    sum_nxt = SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r <= in_valid;
      vld_r[0] <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r     <= px[SQ_W-1:0];
      sqy_r     <= py[SQ_W-1:0];
      sqz_r     <= pz[SQ_W-1:0];
      sq_tag_r  <= in_tag;
      tag_r[0]  <= sq_tag_r;
      sum_r[0]  <= sum_nxt;
      root_r[0] <= '0;
      rem_r[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_step
    localparam int P = ROOT_W - k;
    logic [1:0]       pair;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             take;

    if (P >= FRAC_BITS) begin : g_data
      assign pair = sum_r[k-1][2*(P-FRAC_BITS)+1 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_r[k-1], pair};
    assign trial  = {2'b00, root_r[k-1], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k]  <= tag_r[k-1];
        root_r[k] <= {root_r[k-1][ROOT_W-2:0], take};
      end
    end

    if (k < ROOT_W) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        end
      end
    end

    if (k < SUM_STEPS) begin : g_sum
      always_ff @(posedge clk) begin
        if (en) begin
          sum_r[k] <= sum_r[k-1];
        end
      end
    end
  end

  assign out_valid = vld_r[ROOT_W];
  assign out_tag   = tag_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];

endmodule

// ===== design/trnr_div.sv =====
// ----------------------------------------------------------------------------
// trnr_div - renormalize lane for one channel
// Forms (255*(Lf + s<<16) + Lf) / (2*Lf) with a restoring divider, one
// quotient bit per stage, then applies the zero-vector, nonpositive and
// saturation rules.
// ----------------------------------------------------------------------------
module trnr_div import trnr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [S_W-1:0] in_s,
  input  logic [ROOT_W-1:0]     in_lf,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_byte
);

  logic [TOP_W-1:0]   top_nxt;
  logic               vld_a_r, zero_a_r;
  logic [TOP_W-1:0]   top_a_r;
  logic [ROOT_W-1:0]  lf_a_r;
  logic [TOP_W-2:0]   top_u;
  logic               nonpos_nxt;
  logic [N_W-1:0]     num_nxt;

  logic               vld_r    [0:QUO_W];
  logic               zero_r   [0:QUO_W];
  logic               nonpos_r [0:QUO_W];
  logic [QUO_W-1:0]   quo_r    [0:QUO_W];
  logic [N_W-1:0]     rem_r    [0:QUO_W-1];
  logic [ROOT_W:0]    den_r    [0:QUO_W-1];

  logic               out_vld_r;
  logic [PIX_W-1:0]   out_byte_r;
  logic [PIX_W-1:0]   byte_nxt;

  always_comb begin
    top_nxt = {{(TOP_W-ROOT_W){1'b0}}, in_lf}
            + {{(TOP_W-S_W-FRAC_BITS){in_s[S_W-1]}}, in_s, {FRAC_BITS{1'b0}}};
    top_u      = top_a_r[TOP_W-2:0];
    nonpos_nxt = top_a_r[TOP_W-1] | (top_a_r == '0);
    num_nxt    = {top_u, {PIX_W{1'b0}}} - N_W'(top_u) + N_W'(lf_a_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r  <= 1'b0;
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_a_r  <= in_valid;
      vld_r[0] <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_a_r    <= (in_lf == '0);
      top_a_r     <= top_nxt;
      lf_a_r      <= in_lf;
      zero_r[0]   <= zero_a_r;
      nonpos_r[0] <= nonpos_nxt;
      quo_r[0]    <= '0;
      rem_r[0]    <= num_nxt;
      den_r[0]    <= {lf_a_r, 1'b0};
    end
  end

  for (genvar i = 1; i <= QUO_W; i++) begin : g_bit
    localparam int B = QUO_W - i;
    logic [N_W-1:0] dsh;
    logic           take;

    assign dsh  = N_W'(den_r[i-1]) << B;
    assign take = (rem_r[i-1] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i]   <= zero_r[i-1];
        nonpos_r[i] <= nonpos_r[i-1];
        quo_r[i]    <= {quo_r[i-1][QUO_W-2:0], take};
      end
    end

    if (i < QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= take ? (rem_r[i-1] - dsh) : rem_r[i-1];
          den_r[i] <= den_r[i-1];
        end
      end
    end
  end

  always_comb begin
    if (zero_r[QUO_W]) begin
      byte_nxt = ZERO_VEC_BYTE;
    end else if (nonpos_r[QUO_W]) begin
      byte_nxt = PIX_ZERO;
    end else if (quo_r[QUO_W][QUO_W-1:PIX_W] != '0) begin
      byte_nxt = PIX_MAX;
    end else begin
      byte_nxt = quo_r[QUO_W][PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_byte_r <= byte_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_byte  = out_byte_r;

endmodule

// ===== design/trnr_skid.sv =====
// ----------------------------------------------------------------------------
// trnr_skid - output register with one skid entry
// Drives the result channel; the skid entry catches the transfer that is in
// flight when the sink stalls, and its full flag freezes the pipeline.
// ----------------------------------------------------------------------------
module trnr_skid import trnr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  input  texel_t      push_data,
  output logic        full,
  trnr_out_if.source  out_txl
);

  logic   out_vld_r, skid_vld_r;
  texel_t out_data_r, skid_data_r;
  logic   push, pop;

  assign push = push_valid & ~skid_vld_r;
  assign pop  = out_vld_r & out_txl.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_vld_r && !pop) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

  assign full              = skid_vld_r;
  assign out_txl.valid     = out_vld_r;
  assign out_txl.red_out   = out_data_r.red;
  assign out_txl.green_out = out_data_r.green;
  assign out_txl.blue_out  = out_data_r.blue;
  assign out_txl.alpha_out = out_data_r.alpha;

endmodule

// ===== design/texel_remap_normal_renorm_top.sv =====
// ----------------------------------------------------------------------------
// texel_remap_normal_renorm_top - RGBA8 texel remap and normal renormalize
// Pass-through, normal-map renormalize, two-channel and single-channel
// swizzle of one texel per cycle while the skid entry is empty.
// ----------------------------------------------------------------------------
// channel   dir  fields                                    transfer
// in_txl    in   red_in green_in blue_in alpha_in          valid & ready
// out_txl   out  red_out green_out blue_out alpha_out      valid & ready
// cfg_wr    in   index data (ready tied high)              valid & ready
//
// One texel per cycle while the skid entry is empty; 41 register stages from the
// input transfer to out valid: input stage, 27 in the length pipeline (squares,
// sum, 25 root bits), 12 in each divider lane (9 quotient bits), output register.
// Synchronous active-low reset clears valid bits and sets the config registers to defaults; no sweep.
// A sink stall fills the skid entry, which then freezes every stage at once.
// ----------------------------------------------------------------------------
module texel_remap_normal_renorm_top import trnr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  trnr_in_if.sink    in_txl,
  trnr_out_if.source out_txl,
  trnr_cfg_if.sink   cfg_wr
);

  mode_t             mode_r;
  logic [SEL_W-1:0]  first_sel_r, second_sel_r;

  logic              en, full;
  logic [PIX_W-1:0]  ch [CHAN_N];
  texel_t            byp_nxt;
  logic [S_W:0]      sx10, sy10, sz10;

  logic              in_vld_r;
  tag_t              in_tag_r;
  logic signed [S_W-1:0] in_sz_r;
  tag_t              tag_nxt;

  logic              sq_vld;
  tag_t              sq_tag;
  logic [ROOT_W-1:0] sq_root;

  tag_t              dl_r [0:DIV_LAT-1];
  tag_t              fin_tag;
  logic              r_vld, g_vld;
  logic [PIX_W-1:0]  r_byte, g_byte;
  texel_t            res;

  // configuration
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_PASS;
      first_sel_r  <= SEL_W'(0);
      second_sel_r <= SEL_W'(1);
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_TEXTURE_MODE:  mode_r       <= mode_t'(cfg_wr.data[1:0]);
        CFG_FIRST_SELECT:  first_sel_r  <= cfg_wr.data[SEL_W-1:0];
        CFG_SECOND_SELECT: second_sel_r <= cfg_wr.data[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  assign en           = ~full;
  assign in_txl.ready = en;

  always_comb begin
    ch[0] = in_txl.red_in;
    ch[1] = in_txl.green_in;
    ch[2] = in_txl.blue_in;
    ch[3] = in_txl.alpha_in;
    unique case (mode_r)
      MODE_PASS:   byp_nxt = '{red: ch[0], green: ch[1], blue: ch[2], alpha: ch[3]};
      MODE_NORMAL: byp_nxt = '{red: ch[0], green: ch[1], blue: PIX_ZERO, alpha: PIX_MAX};
      MODE_TWO_CH: byp_nxt = '{red: ch[first_sel_r], green: ch[second_sel_r],
                               blue: PIX_ZERO, alpha: PIX_MAX};
      MODE_ONE_CH: byp_nxt = '{red: ch[first_sel_r], green: PIX_ZERO,
                               blue: PIX_ZERO, alpha: PIX_MAX};
      default:     byp_nxt = '{red: ch[0], green: ch[1], blue: ch[2], alpha: ch[3]};
    endcase
    sx10 = {1'b0, in_txl.red_in, 1'b0} - S_OFFSET;
    sy10 = {1'b0, in_txl.green_in, 1'b0} - S_OFFSET;
    sz10 = {1'b0, in_txl.blue_in, 1'b0} - S_OFFSET;
    tag_nxt.normal = (mode_r == MODE_NORMAL);
    tag_nxt.sx     = sx10[S_W-1:0];
    tag_nxt.sy     = sy10[S_W-1:0];
    tag_nxt.texel  = byp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_txl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_tag_r <= tag_nxt;
      in_sz_r  <= sz10[S_W-1:0];
    end
  end

  // length
  trnr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_vld_r),
    .in_tag    (in_tag_r),
    .in_sz     (in_sz_r),
    .out_valid (sq_vld),
    .out_tag   (sq_tag),
    .out_root  (sq_root)
  );

  // renormalize lanes
  trnr_div u_div_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_vld),
    .in_s      (sq_tag.sx),
    .in_lf     (sq_root),
    .out_valid (r_vld),
    .out_byte  (r_byte)
  );

  trnr_div u_div_g (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_vld),
    .in_s      (sq_tag.sy),
    .in_lf     (sq_root),
    .out_valid (g_vld),
    .out_byte  (g_byte)
  );

  // tag delay matching the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= sq_tag;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  assign fin_tag = dl_r[DIV_LAT-1];

  always_comb begin
    if (fin_tag.normal) begin
      res = '{red: r_byte, green: g_byte, blue: PIX_ZERO, alpha: PIX_MAX};
    end else begin
      res = fin_tag.texel;
    end
  end

  trnr_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (r_vld & g_vld),
    .push_data  (res),
    .full       (full),
    .out_txl    (out_txl)
  );

endmodule

// ===== test/tb_texel_remap_normal_renorm_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_texel_remap_normal_renorm_top - testbench of the texel remap block
// Streams texels through all four texture modes under several register
// settings and idle patterns, predicts every result texel in integer
// arithmetic and compares each output transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb_texel_remap_normal_renorm_top import trnr_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int                   RAND_PHASES    = 12;
  localparam int                   PHASE_ITEMS    = 107;
  localparam int                   SINK_HOLD_CYC  = 400;
  localparam int                   DRAIN_CYC      = 60;
  localparam int                   CYCLE_LIMIT    = 200000;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic clk;
  logic rst_n;

  trnr_in_if  in_txl ();
  trnr_out_if out_txl ();
  trnr_cfg_if cfg_wr ();

  texel_remap_normal_renorm_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_txl  (in_txl),
    .out_txl (out_txl),
    .cfg_wr  (cfg_wr)
  );

  texel_t     texels_to_send[$];
  texel_t     expected_texels[$];
  mode_t      cur_mode;
  logic [1:0] cur_first;
  logic [1:0] cur_second;
  int         idle_mode;
  bit         hold_req;
  bit         sink_hold;
  int         mismatches;
  int         cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- predictor ----

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem  = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [PIX_W-1:0] renorm_byte(longint s, longint unsigned lf);
    longint lfs;
    longint top;
    longint num;
    longint den;
    longint q;
    if (lf == 0) return ZERO_VEC_BYTE;
    lfs = longint'(lf);
    top = lfs + s * (longint'(1) << FRAC_BITS);
    if (top <= 0) return PIX_ZERO;
    num = 255 * top;
    den = 2 * lfs;
    q   = (2 * num + den) / (2 * den);
    if (q > 255) return PIX_MAX;
    return q[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] chan_of(texel_t t, logic [1:0] sel);
    case (sel)
      2'd0:    return t.red;
      2'd1:    return t.green;
      2'd2:    return t.blue;
      default: return t.alpha;
    endcase
  endfunction

  function automatic texel_t remap_texel(texel_t t);
    texel_t          r;
    longint          sx;
    longint          sy;
    longint          sz;
    longint unsigned sum;
    longint unsigned lf;
    r = t;
    case (cur_mode)
      MODE_NORMAL: begin
        sx      = 2 * longint'(t.red) - 255;
        sy      = 2 * longint'(t.green) - 255;
        sz      = 2 * longint'(t.blue) - 255;
        sum     = longint'(sx * sx + sy * sy + sz * sz);
        lf      = floor_sqrt(sum << (2 * FRAC_BITS));
        r.red   = renorm_byte(sx, lf);
        r.green = renorm_byte(sy, lf);
        r.blue  = PIX_ZERO;
        r.alpha = PIX_MAX;
      end
      MODE_TWO_CH: begin
        r.red   = chan_of(t, cur_first);
        r.green = chan_of(t, cur_second);
        r.blue  = PIX_ZERO;
        r.alpha = PIX_MAX;
      end
      MODE_ONE_CH: begin
        r.red   = chan_of(t, cur_first);
        r.green = PIX_ZERO;
        r.blue  = PIX_ZERO;
        r.alpha = PIX_MAX;
      end
      default: r = t;
    endcase
    return r;
  endfunction

  // ---- stimulus helpers ----

  function automatic void queue_texel(texel_t t);
    texels_to_send.insert(texels_to_send.size(), t);
  endfunction

  function automatic logic [PIX_W-1:0] edge_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'hFE;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic texel_t rand_texel(mode_t m);
    texel_t t;
    int     kind;
    t    = texel_t'($urandom);
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      t = {edge_byte(), edge_byte(), edge_byte(), edge_byte()};
    end else if (m == MODE_NORMAL && kind >= 6) begin
      t.red   = 8'($urandom_range(118, 137));
      t.green = 8'($urandom_range(118, 137));
      t.blue  = 8'($urandom_range(118, 137));
    end
    return t;
  endfunction

  function automatic bit sender_pause();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 54;
      IDLE_BOTH: return $urandom_range(0, 99) < 8;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 54;
      IDLE_BOTH: return $urandom_range(0, 99) < 8;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= val;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    case (idx)
      CFG_TEXTURE_MODE:  cur_mode   = mode_t'(val[1:0]);
      CFG_FIRST_SELECT:  cur_first  = val[1:0];
      CFG_SECOND_SELECT: cur_second = val[1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (texels_to_send.size() != 0 || expected_texels.size() != 0) @(negedge clk);
  endtask

  // ---- input driver ----

  always @(posedge clk) begin
    if (!rst_n) begin
      in_txl.valid    <= 1'b0;
      in_txl.red_in   <= '0;
      in_txl.green_in <= '0;
      in_txl.blue_in  <= '0;
      in_txl.alpha_in <= '0;
    end else begin
      if (in_txl.valid && in_txl.ready) begin
        expected_texels.insert(expected_texels.size(),
                               remap_texel(texels_to_send.pop_front()));
      end
      if (!(in_txl.valid && !in_txl.ready)) begin
        if (texels_to_send.size() != 0 && !sender_pause()) begin
          in_txl.valid    <= 1'b1;
          in_txl.red_in   <= texels_to_send[0].red;
          in_txl.green_in <= texels_to_send[0].green;
          in_txl.blue_in  <= texels_to_send[0].blue;
          in_txl.alpha_in <= texels_to_send[0].alpha;
        end else begin
          in_txl.valid <= 1'b0;
        end
      end
    end
  end

  // ---- output monitor ----

  always @(posedge clk) begin
    texel_t exp_t;
    if (!rst_n) begin
      out_txl.ready <= 1'b0;
    end else begin
      if (out_txl.valid && out_txl.ready) begin
        if (expected_texels.size() == 0) begin
          $error("unexpected output transfer: %h %h %h %h", out_txl.red_out,
                 out_txl.green_out, out_txl.blue_out, out_txl.alpha_out);
          mismatches++;
        end else begin
          exp_t = expected_texels.pop_front();
          if (out_txl.red_out !== exp_t.red) begin
            $error("red_out expected %0d got %0d", exp_t.red, out_txl.red_out);
            mismatches++;
          end
          if (out_txl.green_out !== exp_t.green) begin
            $error("green_out expected %0d got %0d", exp_t.green, out_txl.green_out);
            mismatches++;
          end
          if (out_txl.blue_out !== exp_t.blue) begin
            $error("blue_out expected %0d got %0d", exp_t.blue, out_txl.blue_out);
            mismatches++;
          end
          if (out_txl.alpha_out !== exp_t.alpha) begin
            $error("alpha_out expected %0d got %0d", exp_t.alpha, out_txl.alpha_out);
            mismatches++;
          end
        end
      end
      out_txl.ready <= !sink_hold && !receiver_stall();
    end
  end

  // long sink hold-off so the pipeline fills and back-pressures the input
  initial begin
    sink_hold = 1'b0;
    wait (hold_req);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (SINK_HOLD_CYC) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---- test sequence ----

  initial begin
    logic [1:0] m;
    idle_mode  = IDLE_NONE;
    hold_req   = 1'b0;
    cur_mode   = MODE_PASS;
    cur_first  = 2'd0;
    cur_second = 2'd1;
    rst_n        <= 1'b0;
    cfg_wr.valid <= 1'b0;
    cfg_wr.index <= '0;
    cfg_wr.data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: pass-through
    queue_texel(texel_t'(32'h0000_0000));
    queue_texel(texel_t'(32'hFFFF_FFFF));
    queue_texel(texel_t'(32'hA55A_C33C));
    wait_idle();

    // two-channel with reset selects
    write_reg(CFG_TEXTURE_MODE, {6'b101010, MODE_TWO_CH});
    queue_texel(texel_t'(32'h1122_3344));
    queue_texel(texel_t'(32'hFF00_807F));
    wait_idle();

    // normal map, upper data bits set
    write_reg(CFG_TEXTURE_MODE, {6'b111111, MODE_NORMAL});
    queue_texel(texel_t'(32'h0000_0000));
    queue_texel(texel_t'(32'hFFFF_FFFF));
    queue_texel(texel_t'(32'h8080_8080));
    queue_texel(texel_t'(32'h7F7F_7F00));
    queue_texel(texel_t'(32'h00FF_7F10));
    queue_texel(texel_t'(32'hFF00_8000));
    queue_texel(texel_t'(32'h007F_7F00));
    queue_texel(texel_t'(32'h8000_8000));
    queue_texel(texel_t'(32'hFF7F_7FFF));
    wait_idle();

    write_reg(CFG_FIRST_SELECT, 8'hFF);
    write_reg(CFG_SECOND_SELECT, 8'hFC);
    write_reg(CFG_TEXTURE_MODE, {6'd0, MODE_TWO_CH});
    queue_texel(texel_t'(32'h0102_0304));
    queue_texel(texel_t'(32'h80FF_00C0));
    wait_idle();

    write_reg(CFG_TEXTURE_MODE, {6'd0, MODE_ONE_CH});
    queue_texel(texel_t'(32'h0102_0304));
    queue_texel(texel_t'(32'hFE01_EF10));
    wait_idle();

    // index past the register list is ignored
    write_reg(CFG_UNUSED_IDX, 8'h00);
    queue_texel(texel_t'(32'hA0B0_C0D0));
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_mode = ph % 4;
      m = 2'((ph / 4 + ph) % 4);
      write_reg(CFG_TEXTURE_MODE, {6'($urandom), m});
      case (ph)
        0: begin
          write_reg(CFG_FIRST_SELECT, {6'($urandom), 2'd0});
          write_reg(CFG_SECOND_SELECT, {6'($urandom), 2'd3});
        end
        1: begin
          write_reg(CFG_FIRST_SELECT, {6'($urandom), 2'd3});
          write_reg(CFG_SECOND_SELECT, {6'($urandom), 2'd0});
        end
        default: begin
          write_reg(CFG_FIRST_SELECT, 8'($urandom));
          write_reg(CFG_SECOND_SELECT, 8'($urandom));
          if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_IDX, 8'($urandom));
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 6 && i == PHASE_ITEMS / 2) wait_idle();
        queue_texel(rand_texel(cur_mode));
      end
      if (ph == 4) hold_req = 1'b1;
      wait_idle();
    end

    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
